// ===== rtl/prt_pkg.sv =====
package prt_pkg;

   localparam int STAMP_BITS = 32;
   localparam int FIELD_BITS = 16;
   localparam int EXP_BITS   = 11;
   localparam int REQ_TDATA_BITS = 48;
   localparam int REQ_TUSER_BITS = 4;
   localparam int RSP_TDATA_BITS = 64;
   localparam int RSP_TUSER_BITS = 4;

   localparam logic [STAMP_BITS-1:0] TIMEOUT_RESET = 32'd1000;
   localparam logic [EXP_BITS-1:0]   EXP_MAX       = 11'h7FF;

   typedef enum logic [1:0] {
      RK_FORWARD = 2'd0,
      RK_REPLY   = 2'd1,
      RK_TICK    = 2'd2,
      RK_SWEEP   = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_FORWARDED  = 4'd0,
      ST_NOT_QUERY  = 4'd1,
      ST_FIFO_FULL  = 4'd2,
      ST_SERVED     = 4'd3,
      ST_LATE       = 4'd4,
      ST_UNKNOWN_ID = 4'd5,
      ST_BAD_REPLY  = 4'd6,
      ST_TICKED     = 4'd7,
      ST_SWEPT      = 4'd8
   } status_type;

   typedef struct packed {
      logic [EXP_BITS-1:0]   expired;
      logic [FIELD_BITS-1:0] client_tag;
      logic [FIELD_BITS-1:0] client_id;
      logic [FIELD_BITS-1:0] our_id;
      status_type            status;
   } result_type;

endpackage

// ===== rtl/prt_ram.sv =====
module prt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/prt_age_cmp.sv =====
module prt_age_cmp (
   input  logic [prt_pkg::STAMP_BITS-1:0] time_now,
   input  logic [prt_pkg::STAMP_BITS-1:0] stamp,
   input  logic [prt_pkg::STAMP_BITS-1:0] timeout,
   output logic                           expired
);

   logic [prt_pkg::STAMP_BITS-1:0] age;

   // age wraps modulo 2^32 along with the time counter
   assign age     = time_now - stamp;
   assign expired = (age >= timeout);

endmodule

// ===== rtl/pending_request_table_timeout.sv =====
// Pending request table with timeout for a request relay.
// Input channel req_*: one word per event. req_tuser carries the kind (forward request,
// reply, time tick, timeout sweep) and the two reply flags; req_tdata carries client ID,
// client tag and reply ID. Every accepted word gives exactly one result word on rsp_*.
// csr_wen/csr_wdata write the timeout in ticks; write it only while the block is idle.
// Ticks and rejected words go from acceptance straight to the result register. S_FWD
// writes the entry of a forwarded request and pushes its ID into the age FIFO; S_LOOKUP
// reads the entry of a checked reply and writes it back freed if it was valid. A sweep
// pops stale or expired heads until a live head or an empty FIFO; each pop reads the
// FIFO memory, then the entry memory, then runs the shared age compare. req_tready is
// low while a word is at work. The next word is taken while a result still waits in the
// output register; a second finished result is held until the receiver takes the first.
// After reset the block sweeps the entry memory to clear all valid flags, one entry per
// cycle, all 2^ID_BITS entries (65536 by default); req_tready stays low meanwhile, while
// csr writes are still taken. The ID counter, time and the FIFO are cleared by reset.
module pending_request_table_timeout #(
   parameter int ID_BITS    = 16,
   parameter int FIFO_DEPTH = 1024,
   parameter int TAG_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // client_id [15:0], client_tag [31:16], reply_id [47:32]
   input  logic [prt_pkg::REQ_TDATA_BITS-1:0]      req_tdata,
   // req_type [1:0], from_forwarder [2], is_response [3]
   input  logic [prt_pkg::REQ_TUSER_BITS-1:0]      req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // our_id [15:0], client_id_out [31:16], client_tag_out [47:32],
   // expired_count [58:48], zero [63:59]
   output logic [prt_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata,
   // status [3:0]
   output logic [prt_pkg::RSP_TUSER_BITS-1:0]      rsp_tuser,
   input  logic                                    csr_wen,
   input  logic [prt_pkg::STAMP_BITS-1:0]          csr_wdata
);

   localparam int TAG_W   = (TAG_BITS < prt_pkg::FIELD_BITS) ? TAG_BITS : prt_pkg::FIELD_BITS;
   localparam int TAG_LO  = 0;
   localparam int CID_LO  = TAG_LO + TAG_W;
   localparam int STMP_LO = CID_LO + prt_pkg::FIELD_BITS;
   localparam int VLD_BIT = STMP_LO + prt_pkg::STAMP_BITS;
   localparam int ENT_W   = VLD_BIT + 1;
   localparam int TBL_DEPTH = 1 << ID_BITS;
   localparam int PTR_W   = $clog2(FIFO_DEPTH);
   localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [6:0] {
      S_CLEAR    = 7'b0000001,
      S_IDLE     = 7'b0000010,
      S_FWD      = 7'b0000100,
      S_LOOKUP   = 7'b0001000,
      S_SW_HEAD  = 7'b0010000,
      S_SW_ID    = 7'b0100000,
      S_SW_CHECK = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [prt_pkg::STAMP_BITS-1:0]  timeout_ff, timeout_in;
   logic [prt_pkg::STAMP_BITS-1:0]  time_ff, time_in;
   logic [ID_BITS-1:0]              idc_ff, idc_in;
   logic [ID_BITS-1:0]              clr_ff, clr_in;
   logic [PTR_W-1:0]                head_ff, head_in;
   logic [PTR_W-1:0]                tail_ff, tail_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [prt_pkg::EXP_BITS-1:0]    exp_ff, exp_in;
   logic [prt_pkg::FIELD_BITS-1:0]  cid_ff, cid_in;
   logic [TAG_W-1:0]                tag_ff, tag_in;
   logic [ID_BITS-1:0]              rid_ff, rid_in;
   logic                            pend_ff, pend_in;
   prt_pkg::result_type             res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   prt_pkg::result_type             rsp_ff;

   logic                            ent_we;
   logic [ID_BITS-1:0]              ent_waddr;
   logic [ENT_W-1:0]                ent_wdata;
   logic [ID_BITS-1:0]              ent_raddr;
   logic [ENT_W-1:0]                ent_rdata;
   logic                            fifo_we;
   logic [ID_BITS-1:0]              fifo_rdata;
   logic                            expired;

   logic                            rsp_free, move, accept, new_res;
   prt_pkg::req_kind_type           kind;
   logic                            from_fwd, is_resp;
   logic [prt_pkg::FIELD_BITS-1:0]  req_rid;
   logic [ID_BITS-1:0]              id_next;
   logic [PTR_W-1:0]                head_next, tail_next;
   logic                            rid_outside;

   prt_ram #(.WIDTH(ENT_W), .DEPTH(TBL_DEPTH)) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   prt_ram #(.WIDTH(ID_BITS), .DEPTH(FIFO_DEPTH)) u_age_fifo (
      .clock (clock),
      .we    (fifo_we),
      .waddr (tail_ff),
      .wdata (id_next),
      .raddr (head_ff),
      .rdata (fifo_rdata)
   );

   prt_age_cmp u_age_cmp (
      .time_now (time_ff),
      .stamp    (ent_rdata[STMP_LO +: prt_pkg::STAMP_BITS]),
      .timeout  (timeout_ff),
      .expired  (expired)
   );

   assign kind     = prt_pkg::req_kind_type'(req_tuser[1:0]);
   assign from_fwd = req_tuser[2];
   assign is_resp  = req_tuser[3];
   assign req_rid  = req_tdata[47:32];
   assign rid_outside = ((req_rid >> ID_BITS) != '0);

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign move       = pend_ff && rsp_free;
   assign req_tready = (state_ff == S_IDLE) && (!pend_ff || rsp_free);
   assign accept     = req_tvalid && req_tready;

   // counter runs 1 .. 2^ID_BITS-2 and wraps to 1
   always_comb begin
      id_next = idc_ff + 1'b1;
      if (id_next == '1) begin
         id_next = ID_BITS'(1);
      end
   end

   assign head_next = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      state_in   = state_ff;
      timeout_in = csr_wen ? csr_wdata : timeout_ff;
      time_in    = time_ff;
      idc_in     = idc_ff;
      clr_in     = clr_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      exp_in     = exp_ff;
      cid_in     = cid_ff;
      tag_in     = tag_ff;
      rid_in     = rid_ff;
      new_res    = 1'b0;
      res_in     = '0;
      ent_we     = 1'b0;
      ent_waddr  = rid_ff;
      ent_wdata  = {1'b0, ent_rdata[ENT_W-2:0]};
      ent_raddr  = req_rid[ID_BITS-1:0];
      fifo_we    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            ent_we    = 1'b1;
            ent_waddr = clr_ff;
            ent_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cid_in = req_tdata[15:0];
               tag_in = req_tdata[16 +: TAG_W];
               rid_in = req_rid[ID_BITS-1:0];
               case (kind)
                  prt_pkg::RK_FORWARD: begin
                     if (is_resp) begin
                        new_res       = 1'b1;
                        res_in.status = prt_pkg::ST_NOT_QUERY;
                     end else if (count_ff == CNT_W'(FIFO_DEPTH)) begin
                        new_res       = 1'b1;
                        res_in.status = prt_pkg::ST_FIFO_FULL;
                     end else begin
                        state_in = S_FWD;
                     end
                  end
                  prt_pkg::RK_REPLY: begin
                     if (!from_fwd || !is_resp) begin
                        new_res       = 1'b1;
                        res_in.status = prt_pkg::ST_BAD_REPLY;
                     end else if (rid_outside) begin
                        new_res       = 1'b1;
                        res_in.status = prt_pkg::ST_UNKNOWN_ID;
                     end else begin
                        state_in = S_LOOKUP;
                     end
                  end
                  prt_pkg::RK_TICK: begin
                     time_in       = time_ff + 1'b1;
                     new_res       = 1'b1;
                     res_in.status = prt_pkg::ST_TICKED;
                  end
                  default: begin
                     exp_in   = '0;
                     state_in = S_SW_HEAD;
                  end
               endcase
            end
         end
         S_FWD: begin
            idc_in    = id_next;
            ent_we    = 1'b1;
            ent_waddr = id_next;
            ent_wdata = {1'b1, time_ff, cid_ff, tag_ff};
            fifo_we   = 1'b1;
            tail_in   = tail_next;
            count_in  = count_ff + 1'b1;
            new_res       = 1'b1;
            res_in.status = prt_pkg::ST_FORWARDED;
            res_in.our_id = prt_pkg::FIELD_BITS'(id_next);
            state_in  = S_IDLE;
         end
         S_LOOKUP: begin
            new_res  = 1'b1;
            state_in = S_IDLE;
            if (!ent_rdata[VLD_BIT]) begin
               res_in.status = prt_pkg::ST_UNKNOWN_ID;
            end else begin
               // free the entry, keep its contents
               ent_we = 1'b1;
               if (expired) begin
                  res_in.status = prt_pkg::ST_LATE;
               end else begin
                  res_in.status     = prt_pkg::ST_SERVED;
                  res_in.client_id  = ent_rdata[CID_LO +: prt_pkg::FIELD_BITS];
                  res_in.client_tag = prt_pkg::FIELD_BITS'(ent_rdata[TAG_LO +: TAG_W]);
               end
            end
         end
         S_SW_HEAD: begin
            if (count_ff == '0) begin
               new_res        = 1'b1;
               res_in.status  = prt_pkg::ST_SWEPT;
               res_in.expired = exp_ff;
               state_in       = S_IDLE;
            end else begin
               state_in = S_SW_ID;
            end
         end
         S_SW_ID: begin
            ent_raddr = fifo_rdata;
            rid_in    = fifo_rdata;
            state_in  = S_SW_CHECK;
         end
         S_SW_CHECK: begin
            if (ent_rdata[VLD_BIT] && !expired) begin
               // live head: stop here
               new_res        = 1'b1;
               res_in.status  = prt_pkg::ST_SWEPT;
               res_in.expired = exp_ff;
               state_in       = S_IDLE;
            end else begin
               if (ent_rdata[VLD_BIT]) begin
                  ent_we = 1'b1;
                  if (exp_ff != prt_pkg::EXP_MAX) begin
                     exp_in = exp_ff + 1'b1;
                  end
               end
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               state_in = S_SW_HEAD;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      pend_in = new_res ? 1'b1 : (move ? 1'b0 : pend_ff);
      rsp_valid_in = move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         timeout_ff   <= prt_pkg::TIMEOUT_RESET;
         time_ff      <= '0;
         idc_ff       <= '0;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         time_ff      <= time_in;
         idc_ff       <= idc_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
      cid_ff <= cid_in;
      tag_ff <= tag_in;
      rid_ff <= rid_in;
      if (new_res) begin
         res_ff <= res_in;
      end
      if (move) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {5'b0, rsp_ff.expired, rsp_ff.client_tag, rsp_ff.client_id,
                        rsp_ff.our_id};

endmodule

// ===== rtl/prt_checker.sv =====
module prt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [prt_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic [prt_pkg::RSP_TUSER_BITS-1:0] rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // table clearing follows reset, so no word is taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input ready straight after reset");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= prt_pkg::ST_SWEPT)
      else $error("status code out of range");

   a_our_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != prt_pkg::ST_FORWARDED |-> rsp_tdata[15:0] == '0)
      else $error("ID given on a word that was not forwarded");

   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != prt_pkg::ST_SWEPT |-> rsp_tdata[58:48] == '0)
      else $error("expired count on a word that is not a sweep");

endmodule

bind pending_request_table_timeout prt_checker u_prt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
